[hw/rtl/risb_pkg.sv]
// risb_pkg: shared types and constants for the RLE image span blitter.
// Holds the sequencer state type, configuration register indexes and
// default sizes. No dependencies.
package risb_pkg;

    // Default sizes, used as top-level parameter defaults
    localparam int DEF_PANEL_W   = 320;
    localparam int DEF_PANEL_H   = 240;
    localparam int DEF_MAX_IMG_W = 256;
    localparam int DEF_MAX_IMG_H = 64;
    localparam int DEF_MAX_SCALE = 8;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMG_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IMG_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE      = 3'd4;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,    // waiting for a run
        ST_START,   // row wrap, empty-run and image-end check
        ST_SEG,     // segment length, x = ox + col*s
        ST_MUL_Y,   // y = oy + row*s
        ST_MUL_W,   // x end = x + n*s, y end = y + s, last flag
        ST_CLIP,    // clip to the panel
        ST_FB,      // fb offset = y0*PANEL_W + x0
        ST_OUT      // span request held until taken
    } state_t;

    function automatic int imax(int a, int b);
        return (a > b) ? a : b;
    endfunction

endpackage

[hw/rtl/risb_clip.sv]
// risb_clip: clips one scaled span rectangle to the panel.
// Combinational; geometry is zero when nothing is left. Uses risb_pkg.
module risb_clip #(
    parameter int PW      = 16,
    parameter int PANEL_W = risb_pkg::DEF_PANEL_W,
    parameter int PANEL_H = risb_pkg::DEF_PANEL_H
) (
    input  logic signed [PW-1:0] x,
    input  logic signed [PW-1:0] xe,
    input  logic signed [PW-1:0] y,
    input  logic signed [PW-1:0] ye,
    output logic                 visible,
    output logic        [PW-1:0] x0,
    output logic        [PW-1:0] y0,
    output logic        [PW-1:0] wd,
    output logic        [PW-1:0] ht
);

    localparam logic signed [PW-1:0] LIM_X = PW'(PANEL_W);
    localparam logic signed [PW-1:0] LIM_Y = PW'(PANEL_H);

    logic signed [PW-1:0] lx0;
    logic signed [PW-1:0] lx1;
    logic signed [PW-1:0] ly0;
    logic signed [PW-1:0] ly1;

    // Clamp the corners to the panel
    always_comb
    begin
        lx0 = x[PW-1] ? '0 : x;
        ly0 = y[PW-1] ? '0 : y;
        lx1 = (xe > LIM_X) ? LIM_X : xe;
        ly1 = (ye > LIM_Y) ? LIM_Y : ye;
    end

    // Hidden spans report zero geometry
    always_comb
    begin
        visible = (lx1 > lx0) && (ly1 > ly0);
        if (visible)
        begin
            x0 = lx0;
            y0 = ly0;
            wd = lx1 - lx0;
            ht = ly1 - ly0;
        end
        else
        begin
            x0 = '0;
            y0 = '0;
            wd = '0;
            ht = '0;
        end
    end

endmodule

[hw/rtl/rle_image_span_blitter.sv]
// rle_image_span_blitter: RLE runs in, clipped RGB565 span rectangles out.
// Top level: sequencer, shared multiplier, config registers. Uses risb_pkg
// and risb_clip.
//
//  channel  | dir | signals                        | holds
//  ---------+-----+--------------------------------+-----------------------------
//  s_*      | in  | s_tvalid/tready/tdata/tuser    | one run request
//  m_*      | out | m_tvalid/tready/tdata/tuser/   | one span request per segment
//           |     | tlast                          |
//  cfg_*    | in  | cfg_we/index/data              | register write, no read-back
//
// A run enters ST_START; each segment (one per image row touched) then steps
// through ST_SEG, ST_MUL_Y, ST_MUL_W, ST_CLIP, ST_FB and ST_OUT, which holds
// while m_tready is low. The single shared multiplier is used four times per
// segment. A zero-length run, or one after the image is complete, returns to idle from ST_START.
// Reset clears position to column 0, row 0 and the registers to their defaults.
// s_tready is high only between runs.
module rle_image_span_blitter #(
    parameter int PANEL_W   = risb_pkg::DEF_PANEL_W,
    parameter int PANEL_H   = risb_pkg::DEF_PANEL_H,
    parameter int MAX_IMG_W = risb_pkg::DEF_MAX_IMG_W,
    parameter int MAX_IMG_H = risb_pkg::DEF_MAX_IMG_H,
    parameter int MAX_SCALE = risb_pkg::DEF_MAX_SCALE
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // run requests
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [31:0]                      s_tdata,   // run_length, run_color
    input  logic                             s_tuser,   // first_run
    // span requests
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [63:0]                      m_tdata,   // span_x, span_y, span_width,
                                                        // span_height, fb_offset,
                                                        // span_color, zero pad
    output logic                             m_tuser,   // visible
    output logic                             m_tlast,   // last
    // configuration writes
    input  logic                             cfg_we,
    input  logic [risb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [risb_pkg::CFG_DATA_W-1:0]  cfg_data
);

    // Widths
    localparam int CW  = (MAX_IMG_W > 1) ? $clog2(MAX_IMG_W) : 1;
    localparam int WW  = $clog2(MAX_IMG_W + 1);
    localparam int RW  = $clog2(MAX_IMG_H + 1);
    localparam int SW  = $clog2(MAX_SCALE + 1);
    localparam int XW  = $clog2(PANEL_W);
    localparam int YW  = $clog2(PANEL_H);
    localparam int XWW = $clog2(PANEL_W + 1);
    localparam int YHW = $clog2(PANEL_H + 1);
    localparam int MA  = risb_pkg::imax(risb_pkg::imax(WW, RW), YW);
    localparam int MB  = risb_pkg::imax(SW, XWW);
    localparam int PW  = risb_pkg::imax(risb_pkg::imax(risb_pkg::imax(WW, RW) + SW,
                             risb_pkg::imax(XWW, YHW)), 10) + 3;
    localparam int FBW = risb_pkg::imax(MA + MB, 17) + 1;

    // Configuration registers
    logic signed [9:0] origin_x_reg;
    logic signed [9:0] origin_y_reg;
    logic        [8:0] img_width_reg;
    logic        [6:0] img_height_reg;
    logic        [3:0] scale_reg;

    // Control state
    risb_pkg::state_t state_reg, state_next;
    logic [CW-1:0]    col_reg, col_next;
    logic [RW-1:0]    row_reg, row_next;

    // Per-run and per-segment payload
    logic [15:0]          len_reg, len_next;
    logic [15:0]          color_reg, color_next;
    logic [WW-1:0]        n_reg, n_next;
    logic signed [PW-1:0] x_reg, x_next;
    logic signed [PW-1:0] xe_reg, xe_next;
    logic signed [PW-1:0] y_reg, y_next;
    logic signed [PW-1:0] ye_reg, ye_next;
    logic                 last_reg, last_next;
    logic                 vis_reg, vis_next;
    logic [PW-1:0]        x0_reg, x0_next;
    logic [PW-1:0]        y0_reg, y0_next;
    logic [PW-1:0]        wd_reg, wd_next;
    logic [PW-1:0]        ht_reg, ht_next;
    logic [16:0]          fb_reg, fb_next;

    // Effective (clamped) settings
    logic [WW-1:0]        w_eff;
    logic [RW-1:0]        h_eff;
    logic [SW-1:0]        s_eff;
    logic signed [PW-1:0] ox;
    logic signed [PW-1:0] oy;

    // Shared multiplier
    logic [MA-1:0]        mul_a;
    logic [MB-1:0]        mul_b;
    logic [MA+MB-1:0]     prod;
    logic signed [PW-1:0] prod_s;
    logic [FBW-1:0]       fb_sum;

    // Segment helpers
    logic [WW-1:0] rem_cols;
    logic [WW-1:0] n_calc;
    logic [WW-1:0] col_sum;
    logic          seg_wrap;
    logic [RW-1:0] row_inc;
    logic          start_wrap;
    logic [RW-1:0] row_chk;

    // Clip outputs
    logic          clip_vis;
    logic [PW-1:0] clip_x0;
    logic [PW-1:0] clip_y0;
    logic [PW-1:0] clip_wd;
    logic [PW-1:0] clip_ht;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg   <= '0;
            origin_y_reg   <= '0;
            img_width_reg  <= 9'd1;
            img_height_reg <= 7'd1;
            scale_reg      <= 4'd1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                risb_pkg::CFG_ORIGIN_X:   origin_x_reg   <= cfg_data;
                risb_pkg::CFG_ORIGIN_Y:   origin_y_reg   <= cfg_data;
                risb_pkg::CFG_IMG_WIDTH:  img_width_reg  <= cfg_data[8:0];
                risb_pkg::CFG_IMG_HEIGHT: img_height_reg <= cfg_data[6:0];
                risb_pkg::CFG_SCALE:      scale_reg      <= cfg_data[3:0];
                default:                  ;
            endcase
        end
    end

    // Clamp settings: zero counts as one, large values saturate
    always_comb
    begin
        if (img_width_reg == '0)
            w_eff = WW'(1);
        else if (32'(img_width_reg) > MAX_IMG_W)
            w_eff = WW'(MAX_IMG_W);
        else
            w_eff = WW'(img_width_reg);

        if (img_height_reg == '0)
            h_eff = RW'(1);
        else if (32'(img_height_reg) > MAX_IMG_H)
            h_eff = RW'(MAX_IMG_H);
        else
            h_eff = RW'(img_height_reg);

        if (scale_reg == '0)
            s_eff = SW'(1);
        else if (32'(scale_reg) > MAX_SCALE)
            s_eff = SW'(MAX_SCALE);
        else
            s_eff = SW'(scale_reg);
    end

    assign ox = PW'(origin_x_reg);
    assign oy = PW'(origin_y_reg);

    // Multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = MB'(s_eff);
        unique case (state_reg)
            risb_pkg::ST_SEG:   mul_a = MA'(col_reg);
            risb_pkg::ST_MUL_Y: mul_a = MA'(row_reg);
            risb_pkg::ST_MUL_W: mul_a = MA'(n_reg);
            risb_pkg::ST_FB:
            begin
                mul_a = MA'(y0_reg[YW-1:0]);
                mul_b = MB'(PANEL_W);
            end
            default:            mul_a = '0;
        endcase
    end

    assign prod   = mul_a * mul_b;
    assign prod_s = signed'(PW'(prod));
    assign fb_sum = FBW'(prod) + FBW'(x0_reg[XW-1:0]);

    // Segment length and row advance
    assign rem_cols   = w_eff - WW'(col_reg);
    assign n_calc     = (len_reg < 16'(rem_cols)) ? WW'(len_reg) : rem_cols;
    assign col_sum    = WW'(col_reg) + n_reg;
    assign seg_wrap   = (col_sum >= w_eff);
    assign row_inc    = RW'(row_reg + RW'(1));
    assign start_wrap = (row_reg < h_eff) && (WW'(col_reg) >= w_eff);
    assign row_chk    = start_wrap ? row_inc : row_reg;

    risb_clip #(
        .PW      (PW),
        .PANEL_W (PANEL_W),
        .PANEL_H (PANEL_H)
    ) u_clip (
        .x       (x_reg),
        .xe      (xe_reg),
        .y       (y_reg),
        .ye      (ye_reg),
        .visible (clip_vis),
        .x0      (clip_x0),
        .y0      (clip_y0),
        .wd      (clip_wd),
        .ht      (clip_ht)
    );

    // Sequencer: next state and datapath updates
    always_comb
    begin
        state_next = state_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        len_next   = len_reg;
        color_next = color_reg;
        n_next     = n_reg;
        x_next     = x_reg;
        xe_next    = xe_reg;
        y_next     = y_reg;
        ye_next    = ye_reg;
        last_next  = last_reg;
        vis_next   = vis_reg;
        x0_next    = x0_reg;
        y0_next    = y0_reg;
        wd_next    = wd_reg;
        ht_next    = ht_reg;
        fb_next    = fb_reg;

        unique case (state_reg)
            risb_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    len_next   = s_tdata[15:0];
                    color_next = s_tdata[31:16];
                    if (s_tuser)
                    begin
                        col_next = '0;
                        row_next = '0;
                    end
                    state_next = risb_pkg::ST_START;
                end
            end
            risb_pkg::ST_START:
            begin
                // column past a lowered width moves to the next row
                if (start_wrap)
                begin
                    col_next = '0;
                    row_next = row_inc;
                end
                if ((row_chk >= h_eff) || (len_reg == '0))
                    state_next = risb_pkg::ST_IDLE;
                else
                    state_next = risb_pkg::ST_SEG;
            end
            risb_pkg::ST_SEG:
            begin
                n_next     = n_calc;
                x_next     = ox + prod_s;
                state_next = risb_pkg::ST_MUL_Y;
            end
            risb_pkg::ST_MUL_Y:
            begin
                y_next     = oy + prod_s;
                state_next = risb_pkg::ST_MUL_W;
            end
            risb_pkg::ST_MUL_W:
            begin
                xe_next    = x_reg + prod_s;
                ye_next    = y_reg + signed'(PW'(s_eff));
                // run ends when its pixels or the image run out
                last_next  = (len_reg == 16'(n_reg)) || (seg_wrap && (row_inc >= h_eff));
                state_next = risb_pkg::ST_CLIP;
            end
            risb_pkg::ST_CLIP:
            begin
                vis_next   = clip_vis;
                x0_next    = clip_x0;
                y0_next    = clip_y0;
                wd_next    = clip_wd;
                ht_next    = clip_ht;
                state_next = risb_pkg::ST_FB;
            end
            risb_pkg::ST_FB:
            begin
                fb_next    = fb_sum[16:0];
                state_next = risb_pkg::ST_OUT;
            end
            risb_pkg::ST_OUT:
            begin
                if (m_tready)
                begin
                    len_next = len_reg - 16'(n_reg);
                    if (seg_wrap)
                    begin
                        col_next = '0;
                        row_next = row_inc;
                    end
                    else
                    begin
                        col_next = CW'(col_sum);
                    end
                    state_next = last_reg ? risb_pkg::ST_IDLE : risb_pkg::ST_SEG;
                end
            end
            default:
            begin
                state_next = risb_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= risb_pkg::ST_IDLE;
            col_reg   <= '0;
            row_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        len_reg   <= len_next;
        color_reg <= color_next;
        n_reg     <= n_next;
        x_reg     <= x_next;
        xe_reg    <= xe_next;
        y_reg     <= y_next;
        ye_reg    <= ye_next;
        last_reg  <= last_next;
        vis_reg   <= vis_next;
        x0_reg    <= x0_next;
        y0_reg    <= y0_next;
        wd_reg    <= wd_next;
        ht_reg    <= ht_next;
        fb_reg    <= fb_next;
    end

    // Ports
    assign s_tready = (state_reg == risb_pkg::ST_IDLE);
    assign m_tvalid = (state_reg == risb_pkg::ST_OUT);
    assign m_tuser  = vis_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = {1'b0, color_reg, fb_reg, ht_reg[3:0], wd_reg[8:0],
                       y0_reg[7:0], x0_reg[8:0]};

    // Checks
    a_ready_excl: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !m_tvalid)
        else $error("run request accepted while a span is pending");

    a_hidden_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata[46:0] == '0))
        else $error("hidden span carries geometry");

    a_col_in_row: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == risb_pkg::ST_SEG) |-> (WW'(col_reg) < w_eff))
        else $error("segment starts past the row end");

    a_row_in_img: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (row_reg < h_eff))
        else $error("span issued past the image end");

    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tlast) |=> s_tready)
        else $error("not idle after the last span of a run");

endmodule
